>>> src/bfti_pkg.sv
// Shared constants, codes and controller/datapath interface types of the Bloom filter core.
package bfti_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int WORD_BITS       = 64;
    localparam int WORD_SEL_W      = 6;
    localparam int HASH_W          = 64;
    localparam int CMD_W           = 2;
    localparam int BITS_SET_W      = 17;

    localparam logic [BITS_SET_W-1:0] BITS_SET_MAX = 17'h1FFFF;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic hash_step;
        logic sweep_write;
        logic mem_read;
        logic update;
        logic load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic new_is_clear;
        logic new_is_lookup;
        logic hash_done;
        logic sweep_last;
        logic last_step;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/bfti_rem.sv
// One hash-to-bit-index lane: mask for a power-of-two filter, else a four-bit-per-step remainder.
module bfti_rem #(
    parameter int FILTER_BITS = bfti_pkg::FILTER_BITS_DEF,
    parameter int IDX_X       = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_step,
    input  logic [bfti_pkg::HASH_W-1:0] i_hash,
    output logic [IDX_X-1:0]            o_idx,
    output logic                        o_done
);

    localparam bit IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;
    localparam int IDX_W   = $clog2(FILTER_BITS);
    localparam int DIG_W   = 4;
    localparam int STEPS   = bfti_pkg::HASH_W / DIG_W;
    localparam int CNT_W   = $clog2(STEPS + 1);

    generate
        if (IS_POW2) begin : g_mask
            logic [IDX_X-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_idx <= IDX_X'(i_hash[IDX_W-1:0]);
                end
            end

            assign o_idx  = r_idx;
            assign o_done = 1'b1;
        end else begin : g_serial
            localparam int T_W = IDX_X + DIG_W;

            logic [bfti_pkg::HASH_W-1:0] r_hash;
            logic [IDX_X-1:0]            r_rem;
            logic [CNT_W-1:0]            r_cnt;
            logic [T_W-1:0]              shifted;
            logic [T_W-1:0]              multiple;
            logic [T_W-1:0]              reduced;

            // Shift in four hash bits; the value is then below 16 * FILTER_BITS, so
            // removing the largest multiple that fits (parallel compares) leaves the remainder.
            always_comb begin
                shifted  = {r_rem, r_hash[bfti_pkg::HASH_W-1 -: DIG_W]};
                multiple = '0;
                for (int j = 1; j < (1 << DIG_W); j++) begin
                    if (shifted >= T_W'(j * FILTER_BITS)) begin
                        multiple = T_W'(j * FILTER_BITS);
                    end
                end
                reduced = shifted - multiple;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_load) begin
                    r_cnt <= '0;
                end else if (i_step && !o_done) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_hash <= i_hash;
                    r_rem  <= '0;
                end else if (i_step && !o_done) begin
                    r_hash <= {r_hash[bfti_pkg::HASH_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_rem  <= reduced[IDX_X-1:0];
                end
            end

            assign o_idx  = r_rem;
            assign o_done = (r_cnt == CNT_W'(STEPS));
        end
    endgenerate

endmodule

>>> src/bfti_dp.sv
// Datapath: index lanes, single-port bit store, set-bit count and result register.
module bfti_dp #(
    parameter int FILTER_BITS = bfti_pkg::FILTER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfti_pkg::t_dp_cmd               i_cmd,
    output bfti_pkg::t_dp_status            o_status,
    input  logic [bfti_pkg::CMD_W-1:0]      i_command,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_a,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_b,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_c,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_may_be_present,
    output logic [bfti_pkg::BITS_SET_W-1:0] o_bits_set
);

    localparam int STORE_WORDS = (FILTER_BITS + bfti_pkg::WORD_BITS - 1) / bfti_pkg::WORD_BITS;
    localparam int WA_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IDX_X       = WA_W + bfti_pkg::WORD_SEL_W;
    localparam int CNT_W       = $clog2(FILTER_BITS + 1);
    localparam int CMP_W       = (CNT_W > bfti_pkg::BITS_SET_W) ? CNT_W : bfti_pkg::BITS_SET_W;

    logic [IDX_X-1:0] idx_a;
    logic [IDX_X-1:0] idx_b;
    logic [IDX_X-1:0] idx_c;
    logic             done_a;
    logic             done_b;
    logic             done_c;

    bfti_rem #(.FILTER_BITS(FILTER_BITS), .IDX_X(IDX_X)) u_rem_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(i_cmd.accept), .i_step(i_cmd.hash_step),
        .i_hash(i_hash_a), .o_idx(idx_a), .o_done(done_a)
    );
    bfti_rem #(.FILTER_BITS(FILTER_BITS), .IDX_X(IDX_X)) u_rem_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(i_cmd.accept), .i_step(i_cmd.hash_step),
        .i_hash(i_hash_b), .o_idx(idx_b), .o_done(done_b)
    );
    bfti_rem #(.FILTER_BITS(FILTER_BITS), .IDX_X(IDX_X)) u_rem_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(i_cmd.accept), .i_step(i_cmd.hash_step),
        .i_hash(i_hash_c), .o_idx(idx_c), .o_done(done_c)
    );

    logic [bfti_pkg::WORD_BITS-1:0] r_mem [STORE_WORDS];
    logic [bfti_pkg::WORD_BITS-1:0] r_rd_data;
    logic [WA_W-1:0]                r_sweep_addr;
    logic [1:0]                     r_step;
    logic                           r_is_insert;
    logic                           r_is_query;
    logic                           r_all_hit;
    logic [CNT_W-1:0]               r_count;
    logic                           r_o_valid;
    logic                           r_present;
    logic [bfti_pkg::BITS_SET_W-1:0] r_bits_set;

    logic [IDX_X-1:0]                   cur_idx;
    logic [WA_W-1:0]                    mem_addr;
    logic [bfti_pkg::WORD_SEL_W-1:0]    bit_pos;
    logic [bfti_pkg::WORD_BITS-1:0]     bit_mask;
    logic                               hit;
    logic                               set_new;
    logic                               mem_we;
    logic [bfti_pkg::WORD_BITS-1:0]     mem_wdata;
    logic [CMP_W-1:0]                   count_x;
    logic [bfti_pkg::BITS_SET_W-1:0]    shown;

    always_comb begin
        case (r_step)
            2'd0:    cur_idx = idx_a;
            2'd1:    cur_idx = idx_b;
            2'd2:    cur_idx = idx_c;
            default: cur_idx = idx_c;
        endcase
        bit_pos   = cur_idx[bfti_pkg::WORD_SEL_W-1:0];
        bit_mask  = {{(bfti_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
        hit       = r_rd_data[bit_pos];
        set_new   = i_cmd.update && r_is_insert && !hit;
        mem_addr  = i_cmd.sweep_write ? r_sweep_addr : cur_idx[IDX_X-1 -: WA_W];
        mem_we    = i_cmd.sweep_write || set_new;
        mem_wdata = i_cmd.sweep_write ? '0 : (r_rd_data | bit_mask);
        count_x   = CMP_W'(r_count);
        shown     = (count_x > CMP_W'(bfti_pkg::BITS_SET_MAX)) ? bfti_pkg::BITS_SET_MAX
                                                               : count_x[bfti_pkg::BITS_SET_W-1:0];
    end

    // Single-port store: one access per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_step       <= '0;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.sweep_write) begin
                r_sweep_addr <= o_status.sweep_last ? '0 : r_sweep_addr + WA_W'(1);
            end
            if (i_cmd.accept) begin
                r_step <= '0;
            end else if (i_cmd.update) begin
                r_step <= r_step + 2'd1;
            end
            if (i_cmd.accept && (i_command == bfti_pkg::CMD_CLEAR)) begin
                r_count <= '0;
            end else if (set_new) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_result) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_insert <= (i_command == bfti_pkg::CMD_INSERT);
            r_is_query  <= (i_command == bfti_pkg::CMD_QUERY);
            r_all_hit   <= 1'b1;
        end else if (i_cmd.update) begin
            r_all_hit   <= r_all_hit && hit;
        end
        if (i_cmd.load_result) begin
            r_present  <= r_is_query && r_all_hit;
            r_bits_set <= shown;
        end
    end

    always_comb begin
        o_status.new_is_clear  = (i_command == bfti_pkg::CMD_CLEAR);
        o_status.new_is_lookup = (i_command == bfti_pkg::CMD_INSERT) ||
                                 (i_command == bfti_pkg::CMD_QUERY);
        o_status.hash_done     = done_a && done_b && done_c;
        o_status.sweep_last    = (r_sweep_addr == WA_W'(STORE_WORDS - 1));
        o_status.last_step     = (r_step == 2'd2);
        o_status.out_free      = !r_o_valid || !i_stall;
    end

    assign o_valid          = r_o_valid;
    assign o_may_be_present = r_present;
    assign o_bits_set       = r_bits_set;

endmodule

>>> src/bfti_ctrl.sv
// Controller state machine: sequences hashing, store accesses, clearing and result hand-off.
module bfti_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  bfti_pkg::t_dp_status i_status,
    output bfti_pkg::t_dp_cmd    o_cmd
);

    bfti_pkg::t_state r_state;
    bfti_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfti_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            bfti_pkg::ST_INIT: begin
                o_cmd.sweep_write = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = bfti_pkg::ST_IDLE;
                end
            end
            bfti_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.new_is_clear) begin
                        n_state = bfti_pkg::ST_CLEAR;
                    end else if (i_status.new_is_lookup) begin
                        n_state = bfti_pkg::ST_HASH;
                    end else begin
                        n_state = bfti_pkg::ST_RESULT;
                    end
                end
            end
            bfti_pkg::ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_status.hash_done) begin
                    n_state = bfti_pkg::ST_READ;
                end
            end
            bfti_pkg::ST_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = bfti_pkg::ST_UPDATE;
            end
            bfti_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.last_step ? bfti_pkg::ST_RESULT : bfti_pkg::ST_READ;
            end
            bfti_pkg::ST_CLEAR: begin
                o_cmd.sweep_write = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = bfti_pkg::ST_RESULT;
                end
            end
            bfti_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = bfti_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfti_pkg::ST_INIT;
            end
        endcase
    end

endmodule

>>> src/bloom_filter_three_index_core.sv
// Top level of the three-index Bloom filter core: controller plus datapath.
//
// Bloom filter over FILTER_BITS bits held as 64-bit words in one single-port
// memory. Each request carries a command (insert, query, clear) and three
// 64-bit hashes; each hash modulo FILTER_BITS picks one bit. Insert sets the
// three bits in a, b, c order, query reports whether all three are set, clear
// zeroes the store. Every request returns exactly one result with the current
// count of set bits (saturated to 17 bits). One request is in flight at a
// time; o_stall is low only while the core waits for a request, and a result
// may sit in the output register under i_stall while the next request runs.
// Sequence, accept to result loaded: insert/query first reduce the hashes
// to indices (a plain mask when FILTER_BITS is a power of two, else a
// remainder taken four hash bits per step over 16 steps, three lanes in
// parallel), then run three read/update pairs on the single memory port,
// then load the result once the output register is free.
// Clear sweeps the store one word per cycle, then loads the result.
// After reset the same clearing pass runs with o_stall high. Command 3
// changes nothing and returns the current count.
module bloom_filter_three_index_core #(
    parameter int FILTER_BITS = bfti_pkg::FILTER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bfti_pkg::CMD_W-1:0]      i_command,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_a,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_b,
    input  logic [bfti_pkg::HASH_W-1:0]     i_hash_c,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_may_be_present,
    output logic [bfti_pkg::BITS_SET_W-1:0] o_bits_set
);

    bfti_pkg::t_dp_cmd    dp_cmd;
    bfti_pkg::t_dp_status dp_status;

    // Controller: sequencing only, no payload.
    bfti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(dp_status),
        .o_cmd   (dp_cmd)
    );

    // Datapath: index lanes, bit store, count, output register.
    bfti_dp #(.FILTER_BITS(FILTER_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_hash_a        (i_hash_a),
        .i_hash_b        (i_hash_b),
        .i_hash_c        (i_hash_c),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_may_be_present(o_may_be_present),
        .o_bits_set      (o_bits_set)
    );

endmodule

>>> src/bfti_chk.sv
// Port-level checker for the Bloom filter core, bound to the top level.
module bfti_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_may_be_present,
    input logic [bfti_pkg::BITS_SET_W-1:0] o_bits_set
);

    // Reset starts the clearing pass: no request taken, no result shown.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("core not quiet after reset");

    // Only one request in flight: stall rises right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second request accepted back to back");

    // A positive query needs at least one set bit.
    a_hit_needs_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_may_be_present) |-> (o_bits_set != '0))
        else $error("query hit with empty filter");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_may_be_present) && $stable(o_bits_set))
        else $error("stalled result changed");

endmodule

bind bloom_filter_three_index_core bfti_chk u_bfti_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_may_be_present(o_may_be_present),
    .o_bits_set      (o_bits_set)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the three-index Bloom filter core: directed and random requests.
module tb;

    typedef logic [bfti_pkg::HASH_W-1:0]     t_hash;
    typedef logic [bfti_pkg::CMD_W-1:0]      t_cmd;
    typedef logic [bfti_pkg::BITS_SET_W-1:0] t_bits_set;

    localparam int   FILTER_BITS   = bfti_pkg::FILTER_BITS_DEF;
    localparam int   STORE_WORDS   = (FILTER_BITS + bfti_pkg::WORD_BITS - 1) / bfti_pkg::WORD_BITS;
    // Command 3 has no package name; the core must leave the store alone.
    localparam t_cmd CMD_UNUSED    = 2'd3;
    localparam int   RANDOM_REQS   = 1080;
    localparam int   GAP_MAX       = 18;
    // Narrow index window: forces repeated indices and query hits.
    localparam int   HOT_SPAN      = 256;
    localparam int   SETTLE_CYCLES = 20;
    localparam int   REPORT_MAX    = 100;
    // Watchdog limit for the whole run, well above the worst case of all requests and clears.
    localparam int   CYCLE_LIMIT   = 400000;

    typedef struct {
        t_cmd  command;
        t_hash hash_a;
        t_hash hash_b;
        t_hash hash_c;
        int    gap;     // idle cycles before this request is offered
        bit    drain;   // hold off until all answers are back
    } t_bloom_req;

    typedef struct {
        logic      may_be_present;
        t_bits_set bits_set;
    } t_bloom_ans;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_cmd      i_command;
    t_hash     i_hash_a;
    t_hash     i_hash_b;
    t_hash     i_hash_c;
    logic      o_valid;
    logic      i_stall;
    logic      o_may_be_present;
    t_bits_set o_bits_set;

    bloom_filter_three_index_core #(
        .FILTER_BITS(FILTER_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_hash_a        (i_hash_a),
        .i_hash_b        (i_hash_b),
        .i_hash_c        (i_hash_c),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_may_be_present(o_may_be_present),
        .o_bits_set      (o_bits_set)
    );

    // Requests waiting to be offered, answers waiting to come back.
    t_bloom_req  hash_requests[$];
    t_bloom_ans  bloom_answers[$];
    // Keys inserted since the last clear (generator view), for re-queries.
    t_bloom_req  live_keys[$];

    // Shadow of the filter store and its population count.
    logic [bfti_pkg::WORD_BITS-1:0] filter_words [STORE_WORDS];
    int unsigned                    ones_count;

    t_bloom_req cur_req;
    int         idle_count;
    int         stall_left;
    bit         quiet_sender;
    bit         quiet_receiver;
    int         cycle_count;
    int         mismatches;
    int         results_seen;
    int         n_insert, n_query, n_hit, n_clear, n_unused;
    int unsigned peak_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned index_of_hash(t_hash h);
        return int'(h % t_hash'(FILTER_BITS));
    endfunction

    // Fresh 64-bit hash whose bit index is idx; upper part random.
    function automatic t_hash hash_for(int unsigned idx);
        t_hash h;
        h = {$urandom, $urandom};
        return h - (h % t_hash'(FILTER_BITS)) + t_hash'(idx);
    endfunction

    function automatic int unsigned pick_index(bit hot);
        return hot ? $urandom_range(0, HOT_SPAN - 1) : $urandom_range(0, FILTER_BITS - 1);
    endfunction

    function automatic void mark_bit(t_hash h);
        int unsigned idx;
        idx = index_of_hash(h);
        if (!filter_words[idx / bfti_pkg::WORD_BITS][idx % bfti_pkg::WORD_BITS]) begin
            filter_words[idx / bfti_pkg::WORD_BITS][idx % bfti_pkg::WORD_BITS] = 1'b1;
            ones_count++;
        end
    endfunction

    function automatic bit filter_bit(t_hash h);
        int unsigned idx;
        idx = index_of_hash(h);
        return filter_words[idx / bfti_pkg::WORD_BITS][idx % bfti_pkg::WORD_BITS];
    endfunction

    // Apply one request to the shadow store and return the answer it yields.
    function automatic t_bloom_ans bloom_apply(t_bloom_req req);
        t_bloom_ans ans;
        ans.may_be_present = 1'b0;
        case (req.command)
            bfti_pkg::CMD_INSERT: begin
                mark_bit(req.hash_a);
                mark_bit(req.hash_b);
                mark_bit(req.hash_c);
            end
            bfti_pkg::CMD_QUERY: begin
                ans.may_be_present = filter_bit(req.hash_a) && filter_bit(req.hash_b)
                                     && filter_bit(req.hash_c);
            end
            bfti_pkg::CMD_CLEAR: begin
                for (int w = 0; w < STORE_WORDS; w++) begin
                    filter_words[w] = '0;
                end
                ones_count = 0;
            end
            default: ;
        endcase
        ans.bits_set = (ones_count > bfti_pkg::BITS_SET_MAX)
                       ? bfti_pkg::BITS_SET_MAX
                       : ones_count[bfti_pkg::BITS_SET_W-1:0];
        return ans;
    endfunction

    task automatic push_req(t_cmd cmd, t_hash a, t_hash b, t_hash c, bit drain);
        t_bloom_req r;
        r.command = cmd;
        r.hash_a  = a;
        r.hash_b  = b;
        r.hash_c  = c;
        r.gap     = quiet_sender ? 0 : $urandom_range(0, GAP_MAX);
        r.drain   = drain;
        hash_requests.push_back(r);
        if (cmd == bfti_pkg::CMD_INSERT) begin
            live_keys.push_back(r);
        end else if (cmd == bfti_pkg::CMD_CLEAR) begin
            live_keys.delete();
        end
    endtask

    task automatic build_stimulus();
        t_bloom_req k;
        t_hash      ones;
        t_hash      ra, rb, rc;
        int         roll;
        bit         hot;
        ones = '1;

        // Directed part: extremes, every command, repeated indices, clear.
        quiet_sender = 1'b0;
        push_req(bfti_pkg::CMD_QUERY,  '0, '0, '0, 1'b0);            // empty store
        push_req(bfti_pkg::CMD_INSERT, '0, ones, 64'h8000_0000_0000_0000, 1'b0); // a, c collide
        push_req(bfti_pkg::CMD_QUERY,  64'h8000_0000_0000_0000, ones, '0, 1'b0);
        push_req(bfti_pkg::CMD_INSERT, hash_for(63), hash_for(64), hash_for(63), 1'b0); // word edge
        push_req(bfti_pkg::CMD_QUERY,  hash_for(63), hash_for(64), hash_for(0), 1'b1);
        push_req(bfti_pkg::CMD_INSERT, hash_for(1000), hash_for(1000), hash_for(1000), 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  hash_for(1000), hash_for(1000), hash_for(1001), 1'b0);
        push_req(CMD_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 1'b0);
        push_req(CMD_UNUSED, ones, ones, ones, 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  ones, '0, hash_for(64), 1'b0);
        push_req(bfti_pkg::CMD_CLEAR,  {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  '0, ones, hash_for(63), 1'b0); // all gone
        push_req(bfti_pkg::CMD_INSERT, hash_for(5), hash_for(6), hash_for(5), 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  hash_for(5), hash_for(6), hash_for(6), 1'b0);
        push_req(bfti_pkg::CMD_CLEAR,  ones, ones, ones, 1'b0);
        ra = {$urandom, $urandom};
        rb = {$urandom, $urandom};
        rc = {$urandom, $urandom};
        push_req(bfti_pkg::CMD_INSERT, ra, rb, rc, 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  ra, rb, rc, 1'b0);
        push_req(bfti_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 ones, 1'b0);
        push_req(bfti_pkg::CMD_QUERY,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 ones, 1'b0);

        // Random part: mostly inserts and queries of known keys, some noise.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 60 == 0) begin
                quiet_sender = ($urandom_range(0, 2) == 0);
            end
            roll = $urandom_range(0, 99);
            hot  = $urandom_range(0, 1);
            if (roll < 40) begin
                push_req(bfti_pkg::CMD_INSERT, hash_for(pick_index(hot)),
                         hash_for(pick_index(hot)), hash_for(pick_index(hot)),
                         $urandom_range(0, 149) == 0);
            end else if (roll < 60 && live_keys.size() > 0) begin
                // same indices as an inserted key, different upper hash bits
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                push_req(bfti_pkg::CMD_QUERY, hash_for(index_of_hash(k.hash_a)),
                         hash_for(index_of_hash(k.hash_b)),
                         hash_for(index_of_hash(k.hash_c)), $urandom_range(0, 149) == 0);
            end else if (roll < 72 && live_keys.size() > 0) begin
                // two known indices, one guess
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                push_req(bfti_pkg::CMD_QUERY, k.hash_a, hash_for(pick_index(1'b1)),
                         k.hash_c, 1'b0);
            end else if (roll < 94) begin
                push_req(bfti_pkg::CMD_QUERY, hash_for(pick_index(hot)),
                         hash_for(pick_index(hot)), hash_for(pick_index(hot)), 1'b0);
            end else if (roll < 97) begin
                push_req(CMD_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 1'b0);
            end else begin
                push_req(bfti_pkg::CMD_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 1'b0);
            end
        end
    endtask

    // Request driver: offers the queue head after its gap; predicts on accept.
    always @(posedge i_clk) begin : drive_reqs
        bit         taken;
        t_bloom_req nxt;
        t_bloom_ans ans;
        taken = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            idle_count <= 0;
        end else begin
            if (taken) begin
                ans = bloom_apply(cur_req);
                bloom_answers.push_back(ans);
                case (cur_req.command)
                    bfti_pkg::CMD_INSERT: n_insert++;
                    bfti_pkg::CMD_QUERY:  n_query++;
                    bfti_pkg::CMD_CLEAR:  n_clear++;
                    default:              n_unused++;
                endcase
                if (ans.may_be_present) n_hit++;
                if (ones_count > peak_count) peak_count = ones_count;
            end
            if (taken || !i_valid) begin
                // a drain request waits for every outstanding answer first
                if (hash_requests.size() > 0 && idle_count >= hash_requests[0].gap
                        && !(hash_requests[0].drain && bloom_answers.size() > 0)) begin
                    nxt        = hash_requests.pop_front();
                    cur_req    = nxt;
                    i_valid    <= 1'b1;
                    i_command  <= nxt.command;
                    i_hash_a   <= nxt.hash_a;
                    i_hash_b   <= nxt.hash_b;
                    i_hash_c   <= nxt.hash_c;
                    idle_count <= 0;
                end else begin
                    i_valid    <= 1'b0;
                    idle_count <= idle_count + 1;
                end
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest answer.
    always @(posedge i_clk) begin : check_results
        t_bloom_ans want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (results_seen % 40 == 0) begin
                    quiet_receiver = ($urandom_range(0, 2) == 0);
                end
                if (bloom_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result: expected none, actual %0b/%0d",
                                 $time, o_may_be_present, o_bits_set);
                end else begin
                    want = bloom_answers.pop_front();
                    if (o_may_be_present !== want.may_be_present) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: may_be_present expected %0b actual %0b",
                                     $time, want.may_be_present, o_may_be_present);
                    end
                    if (o_bits_set !== want.bits_set) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: bits_set expected %0d actual %0d",
                                     $time, want.bits_set, o_bits_set);
                    end
                end
                stall_left = quiet_receiver ? 0 : $urandom_range(0, GAP_MAX);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, bloom_answers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : run
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = bfti_pkg::CMD_INSERT;
        i_hash_a       = '0;
        i_hash_b       = '0;
        i_hash_c       = '0;
        i_stall        = 1'b0;
        stall_left     = 0;
        quiet_receiver = 1'b0;
        cycle_count    = 0;
        mismatches     = 0;
        results_seen   = 0;
        n_insert       = 0;
        n_query        = 0;
        n_hit          = 0;
        n_clear        = 0;
        n_unused       = 0;
        peak_count     = 0;
        ones_count     = 0;
        for (int w = 0; w < STORE_WORDS; w++) begin
            filter_words[w] = '0;
        end
        build_stimulus();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (hash_requests.size() > 0 || i_valid) @(posedge i_clk);
        while (bloom_answers.size() > 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts, %0d queries (%0d hits), %0d clears, %0d unused commands",
                 n_insert, n_query, n_hit, n_clear, n_unused);
        $display("%0d results checked, peak population %0d bits, %0d mismatches",
                 results_seen, peak_count, mismatches);
        if (mismatches == 0 && bloom_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
